// File: rtl/trci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trci_pkg
// Shared constants and types for the triangle scan and color interpolation
// core.
// ----------------------------------------------------------------------------
package trci_pkg;

   localparam int COORD_BITS_DEF   = 10;
   localparam int CHANNEL_BITS_DEF = 8;
   localparam int CSR_ADDR_BITS    = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_VERTEX_ZERO = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VERTEX_ONE  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VERTEX_TWO  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic start;    // latch pixel and begin edge evaluation unless the box is empty
      logic restart;  // beat asked for a restart
      logic out_take; // output register consumed
   } trci_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic done;     // result ready in output register
   } trci_sts_type;

endpackage

// File: rtl/triangle_raster_color_interp_core.sv
`timescale 1ns / 1ps
// One pixel at a time: a new request is taken only after the previous response
// beat and the return to idle. The shared radix-2 divider serves the color
// channels in turn, each quotient QW = 2*COORD_BITS+CHANNEL_BITS+8 bits wide (36
// by default). An uncovered pixel skips the divider; an empty box skips both.
// Reset: synchronous, clears vertices, scan position and all control state.
// ----------------------------------------------------------------------------
// triangle_raster_color_interp_core
// Bounding-box triangle scan with edge-function coverage and per-channel
// barycentric color interpolation.
// ----------------------------------------------------------------------------
module triangle_raster_color_interp_core #(
   parameter int COORD_BITS   = trci_pkg::COORD_BITS_DEF,
   parameter int CHANNEL_BITS = trci_pkg::CHANNEL_BITS_DEF,
   parameter int VERT_BITS    = 2 * COORD_BITS + 3 * CHANNEL_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [trci_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [VERT_BITS-1:0]               csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [COORD_BITS-1:0]              rsp_pixel_x,
   output logic [COORD_BITS-1:0]              rsp_pixel_y,
   output logic                               rsp_covered,
   output logic [CHANNEL_BITS-1:0]            rsp_red,
   output logic [CHANNEL_BITS-1:0]            rsp_green,
   output logic [CHANNEL_BITS-1:0]            rsp_blue,
   output logic                               rsp_box_end
);
   import trci_pkg::*;

   logic [VERT_BITS-1:0] vert_ff [3];
   trci_cmd_type cmd;
   trci_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) vert_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VERTEX_ZERO: vert_ff[0] <= csr_data;
            CSR_VERTEX_ONE:  vert_ff[1] <= csr_data;
            CSR_VERTEX_TWO:  vert_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   trci_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_restart,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   trci_datapath #(
      .COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS), .VERT_BITS(VERT_BITS)
   ) u_dp (
      .clock, .reset,
      .vert_0(vert_ff[0]), .vert_1(vert_ff[1]), .vert_2(vert_ff[2]),
      .cmd, .sts,
      .pixel_x(rsp_pixel_x), .pixel_y(rsp_pixel_y), .covered(rsp_covered),
      .red(rsp_red), .green(rsp_green), .blue(rsp_blue), .box_end(rsp_box_end)
   );

endmodule

// File: rtl/trci_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trci_datapath
// Box bounds, scan position, edge functions, and a radix-2 divider shared by
// the three color channels.
// ----------------------------------------------------------------------------
module trci_datapath #(
   parameter int COORD_BITS   = trci_pkg::COORD_BITS_DEF,
   parameter int CHANNEL_BITS = trci_pkg::CHANNEL_BITS_DEF,
   parameter int VERT_BITS    = 2 * COORD_BITS + 3 * CHANNEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VERT_BITS-1:0]          vert_0,
   input  logic [VERT_BITS-1:0]          vert_1,
   input  logic [VERT_BITS-1:0]          vert_2,
   input  trci_pkg::trci_cmd_type        cmd,
   output trci_pkg::trci_sts_type        sts,
   output logic [COORD_BITS-1:0]         pixel_x,
   output logic [COORD_BITS-1:0]         pixel_y,
   output logic                          covered,
   output logic [CHANNEL_BITS-1:0]       red,
   output logic [CHANNEL_BITS-1:0]       green,
   output logic [CHANNEL_BITS-1:0]       blue,
   output logic                          box_end
);
   import trci_pkg::*;

   localparam int CW  = COORD_BITS + 2;          // signed coordinate difference
   localparam int WW  = 2 * CW + 1;              // edge value
   localparam int NW  = WW + CHANNEL_BITS + 3;   // weighted sum
   localparam int QW  = NW;                      // quotient bits
   localparam int DCW = $clog2(QW + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EDGE, S_WSUM, S_DIV, S_DONE
   } dp_state_type;

   logic [COORD_BITS-1:0] x0, x1, x2, y0, y1, y2;
   logic [CHANNEL_BITS-1:0] ch0 [3], ch1 [3], ch2 [3];
   assign x0 = vert_0[COORD_BITS-1:0];
   assign x1 = vert_1[COORD_BITS-1:0];
   assign x2 = vert_2[COORD_BITS-1:0];
   assign y0 = vert_0[2*COORD_BITS-1:COORD_BITS];
   assign y1 = vert_1[2*COORD_BITS-1:COORD_BITS];
   assign y2 = vert_2[2*COORD_BITS-1:COORD_BITS];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ch0[c] = vert_0[2*COORD_BITS + (2-c)*CHANNEL_BITS +: CHANNEL_BITS];
         ch1[c] = vert_1[2*COORD_BITS + (2-c)*CHANNEL_BITS +: CHANNEL_BITS];
         ch2[c] = vert_2[2*COORD_BITS + (2-c)*CHANNEL_BITS +: CHANNEL_BITS];
      end
   end

   logic [COORD_BITS-1:0] xmin, xmax, ymin, ymax;
   always_comb begin
      xmin = (x0 < x1) ? x0 : x1;
      xmin = (xmin < x2) ? xmin : x2;
      xmax = (x0 > x1) ? x0 : x1;
      xmax = (xmax > x2) ? xmax : x2;
      ymin = (y0 < y1) ? y0 : y1;
      ymin = (ymin < y2) ? ymin : y2;
      ymax = (y0 > y1) ? y0 : y1;
      ymax = (ymax > y2) ? ymax : y2;
   end

   logic empty;
   assign empty = (xmin == xmax) || (ymin == ymax);

   dp_state_type          state_ff;
   logic [COORD_BITS-1:0] scan_col_ff, scan_row_ff;
   logic                  scan_running_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic                  last_ff;
   logic [1:0]            step_ff;   // edge or channel index
   logic signed [WW-1:0]  w_ff [3];
   logic signed [WW+1:0]  den_ff;
   logic signed [NW-1:0]  num_ff;
   logic [NW-1:0]         rem_ff;
   logic [QW-1:0]         quo_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic                  cov_ff;
   logic [CHANNEL_BITS-1:0] col_ff [3];

   logic restart_pos;
   logic [COORD_BITS-1:0] px_sel, py_sel;
   always_comb begin
      restart_pos = cmd.restart || !scan_running_ff || empty ||
                    scan_col_ff < xmin || scan_col_ff >= xmax ||
                    scan_row_ff < ymin || scan_row_ff >= ymax;
      px_sel = restart_pos ? xmin : scan_col_ff;
      py_sel = restart_pos ? ymin : scan_row_ff;
   end

   // One edge function per cycle.
   logic signed [CW-1:0] ax, ay, bx, by, ppx, ppy;
   logic signed [WW-1:0] edge_val;
   always_comb begin
      unique case (step_ff)
         2'd0: begin ax = CW'(x1); ay = CW'(y1); bx = CW'(x2); by = CW'(y2); end
         2'd1: begin ax = CW'(x2); ay = CW'(y2); bx = CW'(x0); by = CW'(y0); end
         default: begin ax = CW'(x0); ay = CW'(y0); bx = CW'(x1); by = CW'(y1); end
      endcase
      ppx = CW'(px_ff);
      ppy = CW'(py_ff);
      edge_val = WW'(bx - ax) * WW'(ppy - ay) - WW'(by - ay) * WW'(ppx - ax);
   end

   // One product per cycle into the weighted sum.
   logic [CHANNEL_BITS-1:0] cv;
   logic signed [NW-1:0]    wprod;
   always_comb begin
      unique case (dcnt_ff[1:0])
         2'd0:    cv = ch0[step_ff];
         2'd1:    cv = ch1[step_ff];
         default: cv = ch2[step_ff];
      endcase
      wprod = NW'(w_ff[dcnt_ff[1:0]]) * $signed({1'b0, cv});
   end

   logic [WW+1:0] uden;
   assign uden = den_ff[WW+1] ? -den_ff : den_ff;
   logic [NW:0] trial;
   assign trial = {rem_ff, quo_ff[QW-1]} - {{(NW-WW-1){1'b0}}, uden};

   logic pos_all, neg_all;
   assign pos_all = (w_ff[0] > 0) && (w_ff[1] > 0) && (w_ff[2] > 0);
   assign neg_all = (w_ff[0] < 0) && (w_ff[1] < 0) && (w_ff[2] < 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         scan_col_ff     <= '0;
         scan_row_ff     <= '0;
         scan_running_ff <= 1'b0;
         step_ff         <= '0;
         dcnt_ff         <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (cmd.start) begin
               px_ff    <= px_sel;
               py_ff    <= py_sel;
               last_ff  <= empty || (px_sel == xmax - 1'b1 && py_sel == ymax - 1'b1);
               cov_ff   <= 1'b0;
               for (int c = 0; c < 3; c++) col_ff[c] <= '0;
               step_ff  <= '0;
               if (empty || (px_sel == xmax - 1'b1 && py_sel == ymax - 1'b1)) begin
                  scan_running_ff <= 1'b0;
                  scan_col_ff     <= xmin;
                  scan_row_ff     <= ymin;
               end else begin
                  scan_running_ff <= 1'b1;
                  if (py_sel + 1'b1 >= ymax || py_sel == '1) begin
                     scan_row_ff <= ymin;
                     scan_col_ff <= px_sel + 1'b1;
                  end else begin
                     scan_row_ff <= py_sel + 1'b1;
                     scan_col_ff <= px_sel;
                  end
               end
               state_ff <= empty ? S_DONE : S_EDGE;
            end
            S_EDGE: begin
               w_ff[step_ff] <= edge_val;
               if (step_ff == 2'd2) begin
                  step_ff  <= '0;
                  state_ff <= S_WSUM;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
               dcnt_ff <= '0;
            end
            S_WSUM: begin
               // step_ff: channel, dcnt_ff[1:0]: vertex
               if (step_ff == 2'd0 && dcnt_ff == '0) begin
                  cov_ff <= pos_all || neg_all;
                  den_ff <= (WW+2)'(w_ff[0]) + (WW+2)'(w_ff[1]) + (WW+2)'(w_ff[2]);
                  if (!(pos_all || neg_all)) state_ff <= S_DONE;
               end
               num_ff <= (dcnt_ff == '0) ? wprod : num_ff + wprod;
               if (dcnt_ff == DCW'(2)) begin
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
                  quo_ff   <= '0;
                  rem_ff   <= '0;
               end else if (!(step_ff == 2'd0 && dcnt_ff == '0 &&
                              !(pos_all || neg_all))) begin
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            S_DIV: begin
               if (dcnt_ff == '0) begin
                  quo_ff  <= den_ff[WW+1] ? QW'(-num_ff) : QW'(num_ff);
                  rem_ff  <= '0;
                  dcnt_ff <= dcnt_ff + 1'b1;
               end else begin
                  if (!trial[NW]) begin
                     rem_ff <= trial[NW-1:0];
                     quo_ff <= {quo_ff[QW-2:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[NW-2:0], quo_ff[QW-1]};
                     quo_ff <= {quo_ff[QW-2:0], 1'b0};
                  end
                  if (dcnt_ff == DCW'(QW)) begin
                     // Quotient complete: store channel and advance.
                     dcnt_ff         <= '0;
                     col_ff[step_ff] <= CHANNEL_BITS'({quo_ff[QW-2:0], !trial[NW]});
                     step_ff         <= step_ff + 1'b1;
                     state_ff        <= (step_ff == 2'd2) ? S_DONE : S_WSUM;
                  end else begin
                     dcnt_ff <= dcnt_ff + 1'b1;
                  end
               end
            end
            S_DONE: if (cmd.out_take) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sts.done = (state_ff == S_DONE);
   assign pixel_x  = px_ff;
   assign pixel_y  = py_ff;
   assign covered  = cov_ff;
   assign red      = col_ff[0];
   assign green    = col_ff[1];
   assign blue     = col_ff[2];
   assign box_end  = last_ff;

endmodule

// File: rtl/trci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trci_ctrl
// Handshake controller: takes a request beat, waits for the datapath result,
// presents it until the response beat completes.
// ----------------------------------------------------------------------------
module trci_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output trci_pkg::trci_cmd_type cmd,
   input  trci_pkg::trci_sts_type sts
);
   import trci_pkg::*;

   typedef enum logic [1:0] { C_IDLE, C_BUSY, C_OUT } ctrl_state_type;
   ctrl_state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         unique case (state_ff)
            C_IDLE: if (req_valid) state_ff <= C_BUSY;
            C_BUSY: if (sts.done) state_ff <= C_OUT;
            C_OUT:  if (!rsp_stall) state_ff <= C_IDLE;
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign req_stall    = (state_ff != C_IDLE);
   assign rsp_valid    = (state_ff == C_OUT);
   assign cmd.start    = (state_ff == C_IDLE) && req_valid;
   assign cmd.restart  = req_restart;
   assign cmd.out_take = (state_ff == C_OUT) && !rsp_stall;

endmodule

// File: tb/sv/tb_triangle_raster_color_interp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_raster_color_interp_core
// Self-checking bench for the triangle scan core: programs vertex sets,
// drives restart/advance beats with random idling on both sides, and checks
// every pixel beat against an in-bench scan and Gouraud color predictor.
// ----------------------------------------------------------------------------
module tb_triangle_raster_color_interp_core;
   import trci_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int HB = CHANNEL_BITS_DEF;
   localparam int VB = 2 * CB + 3 * HB;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN = 200;

   typedef struct packed {
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic          cov;
      logic [HB-1:0] r;
      logic [HB-1:0] g;
      logic [HB-1:0] b;
      logic          last;
   } pixel_type;

   typedef struct {
      logic      restart;
      logic      known;
      pixel_type pix;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [CSR_ADDR_BITS-1:0] csr_index = CSR_VERTEX_ZERO;
   logic [VB-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_restart = 0;
   logic rsp_stall = 0;
   logic req_stall, rsp_valid, rsp_covered, rsp_box_end;
   logic [CB-1:0] rsp_pixel_x, rsp_pixel_y;
   logic [HB-1:0] rsp_red, rsp_green, rsp_blue;

   triangle_raster_color_interp_core u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic [VB-1:0] vert [3];
   logic [CB-1:0] next_col, next_row;
   logic          scanning;
   pixel_type     pixel_queue [$];
   pixel_type     known_queue [$];
   logic          known_flag [$];
   int            errors = 0;
   int            idle_cycles = 0;
   int            stall_pct = 17;
   logic          timed_out = 0;

   function automatic longint vx(int i);
      return longint'(vert[i][CB-1:0]);
   endfunction
   function automatic longint vy(int i);
      return longint'(vert[i][2*CB-1:CB]);
   endfunction
   function automatic longint vch(int i, int ch);
      return longint'((vert[i] >> (2 * CB + (2 - ch) * HB)) & ((1 << HB) - 1));
   endfunction
   function automatic longint edge_fn(int a, int c, longint x, longint y);
      return (vx(c) - vx(a)) * (y - vy(a)) - (vy(c) - vy(a)) * (x - vx(a));
   endfunction

   function automatic pixel_type scan_pixel(logic rst);
      pixel_type p;
      longint xmn, xmx, ymn, ymx, x, y, w0, w1, w2, den, num;
      longint q [3];
      logic flat;
      xmn = vx(0); xmx = vx(0); ymn = vy(0); ymx = vy(0);
      for (int i = 1; i < 3; i++) begin
         if (vx(i) < xmn) xmn = vx(i);
         if (vx(i) > xmx) xmx = vx(i);
         if (vy(i) < ymn) ymn = vy(i);
         if (vy(i) > ymx) ymx = vy(i);
      end
      flat = (xmn == xmx) || (ymn == ymx);
      x = next_col; y = next_row;
      if (rst || !scanning || flat || x < xmn || x >= xmx || y < ymn || y >= ymx) begin
         x = xmn; y = ymn;
      end
      p = '0;
      p.px = x[CB-1:0];
      p.py = y[CB-1:0];
      if (flat) begin
         p.last = 1;
      end else begin
         w0 = edge_fn(1, 2, x, y);
         w1 = edge_fn(2, 0, x, y);
         w2 = edge_fn(0, 1, x, y);
         p.cov = (w0 > 0 && w1 > 0 && w2 > 0) || (w0 < 0 && w1 < 0 && w2 < 0);
         if (p.cov) begin
            den = w0 + w1 + w2;
            for (int ch = 0; ch < 3; ch++) begin
               num = w0 * vch(0, ch) + w1 * vch(1, ch) + w2 * vch(2, ch);
               if (den < 0) q[ch] = (-num) / (-den);
               else q[ch] = num / den;
            end
            p.r = q[0][HB-1:0]; p.g = q[1][HB-1:0]; p.b = q[2][HB-1:0];
         end
         p.last = (x == xmx - 1) && (y == ymx - 1);
      end
      if (p.last) begin
         scanning = 0; next_col = xmn[CB-1:0]; next_row = ymn[CB-1:0];
      end else begin
         scanning = 1;
         if (y + 1 >= ymx) begin
            next_row = ymn[CB-1:0]; next_col = CB'(x + 1);
         end else begin
            next_row = CB'(y + 1); next_col = x[CB-1:0];
         end
      end
      return p;
   endfunction

   function automatic logic [VB-1:0] mk_vert(int x, int y, int r, int g, int b);
      return {HB'(r), HB'(g), HB'(b), CB'(y), CB'(x)};
   endfunction

   task automatic write_vertex(logic [CSR_ADDR_BITS-1:0] idx, logic [VB-1:0] val);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      vert[idx] = val;
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic settle;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic load_triangle(logic [VB-1:0] a, logic [VB-1:0] b, logic [VB-1:0] c);
      settle();
      write_vertex(CSR_VERTEX_ZERO, a);
      write_vertex(CSR_VERTEX_ONE, b);
      write_vertex(CSR_VERTEX_TWO, c);
   endtask

   task automatic send_beat(logic rst, logic known, pixel_type want, logic idle);
      pixel_type p;
      if (idle) begin
         while ($urandom_range(99) < stall_pct) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_restart <= rst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = scan_pixel(rst);
      pixel_queue.push_back(p);
      known_flag.push_back(known);
      known_queue.push_back(want);
      req_valid <= 0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      pixel_type got, want, typed;
      logic      kn;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pixel_x, rsp_pixel_y, rsp_covered, rsp_red, rsp_green, rsp_blue,
                rsp_box_end};
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel beat %h", $time, got);
            errors++;
         end else begin
            want = pixel_queue.pop_front();
            kn = known_flag.pop_front();
            typed = known_queue.pop_front();
            if (kn && typed !== want) begin
               $display("%0t: table row disagrees: exp %h act %h", $time, typed, want);
               errors++;
            end
            if (got.px !== want.px) begin
               $display("%0t: pixel_x exp %0d act %0d", $time, want.px, got.px); errors++;
            end
            if (got.py !== want.py) begin
               $display("%0t: pixel_y exp %0d act %0d", $time, want.py, got.py); errors++;
            end
            if (got.cov !== want.cov) begin
               $display("%0t: covered exp %0d act %0d", $time, want.cov, got.cov); errors++;
            end
            if (got.r !== want.r) begin
               $display("%0t: red exp %0d act %0d", $time, want.r, got.r); errors++;
            end
            if (got.g !== want.g) begin
               $display("%0t: green exp %0d act %0d", $time, want.g, got.g); errors++;
            end
            if (got.b !== want.b) begin
               $display("%0t: blue exp %0d act %0d", $time, want.b, got.b); errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: box_end exp %0d act %0d", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic pixel_type pix(int x, int y, int c, int r, int g, int b, int l);
      pixel_type p;
      p.px = CB'(x); p.py = CB'(y); p.cov = c[0];
      p.r = HB'(r); p.g = HB'(g); p.b = HB'(b); p.last = l[0];
      return p;
   endfunction

   function automatic logic [VB-1:0] rand_vert(int span);
      int bx, by;
      bx = $urandom_range(1023 - span);
      by = $urandom_range(1023 - span);
      return {HB'($urandom), HB'($urandom), HB'($urandom),
              CB'(by + $urandom_range(span)), CB'(bx + $urandom_range(span))};
   endfunction

   dir_row_type dir_rows [$];
   int sent;

   initial begin
      vert[0] = '0; vert[1] = '0; vert[2] = '0;
      next_col = '0; next_row = '0; scanning = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // all-zero vertices after reset: empty box at the origin
      dir_rows.push_back('{1'b0, 1'b1, pix(0, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{1'b1, 1'b1, pix(0, 0, 0, 0, 0, 0, 1)});
      foreach (dir_rows[i]) send_beat(dir_rows[i].restart, dir_rows[i].known,
                                      dir_rows[i].pix, 1);
      dir_rows.delete();

      // extreme corners, full-scale colors; box too large to walk, so restart
      load_triangle(mk_vert(0, 0, 255, 0, 0), mk_vert(1023, 0, 0, 255, 0),
                    mk_vert(0, 1023, 0, 0, 255));
      dir_rows.push_back('{1'b1, 1'b1, pix(0, 0, 0, 0, 0, 0, 0)});
      for (int i = 0; i < 4; i++) dir_rows.push_back('{1'b0, 1'b0, '0});
      dir_rows.push_back('{1'b1, 1'b1, pix(0, 0, 0, 0, 0, 0, 0)});
      foreach (dir_rows[i]) send_beat(dir_rows[i].restart, dir_rows[i].known,
                                      dir_rows[i].pix, 1);
      dir_rows.delete();

      // two small triangles of the same winding, walked to the end
      load_triangle(mk_vert(10, 10, 255, 255, 255), mk_vert(14, 10, 0, 128, 255),
                    mk_vert(10, 14, 255, 0, 7));
      for (int i = 0; i < 17; i++) send_beat(i == 0, 0, '0, 1);
      load_triangle(mk_vert(1023, 1023, 1, 2, 3), mk_vert(1019, 1023, 200, 100, 50),
                    mk_vert(1023, 1018, 0, 255, 0));
      for (int i = 0; i < 22; i++) send_beat(0, 0, '0, 1);
      // degenerate (collinear) and flat boxes
      load_triangle(mk_vert(3, 3, 9, 9, 9), mk_vert(5, 5, 9, 9, 9), mk_vert(7, 7, 9, 9, 9));
      for (int i = 0; i < 5; i++) send_beat(0, 0, '0, 1);
      load_triangle(mk_vert(8, 20, 1, 1, 1), mk_vert(8, 30, 2, 2, 2), mk_vert(8, 40, 3, 3, 3));
      send_beat(0, 1, pix(8, 20, 0, 0, 0, 0, 1), 1);

      // random triangles: mostly small boxes walked through, some restarts
      sent = 0;
      while (sent < 1700) begin
         int span, n;
         span = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
         load_triangle(rand_vert(span), rand_vert(span), rand_vert(span));
         // stale position: rewrite one vertex mid-scan sometimes
         n = $urandom_range(5, 60);
         stall_pct = (sent > 700 && sent < 900) ? 0 : 17;
         for (int i = 0; i < n; i++) begin
            send_beat($urandom_range(19) == 0, 0, '0, 1);
            sent++;
         end
         if ($urandom_range(3) == 0) begin
            settle();
            write_vertex(CSR_ADDR_BITS'($urandom_range(2)), rand_vert(span));
            for (int i = 0; i < 6; i++) begin
               send_beat(0, 0, '0, 1);
               sent++;
            end
         end
      end

      settle();
      if (errors == 0 && pixel_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
